// File: hw/rtl/kmp_pkg.sv
// Shared types and constants for the KMP first-match finder.
`timescale 1ns / 1ps

package kmp_pkg;

   localparam int PATTERN_MAX = 16;
   localparam int IDX_W       = $clog2(PATTERN_MAX);
   localparam int LEN_W       = IDX_W + 1;
   localparam int POS_BITS    = 16;
   localparam int START_W     = 16;
   localparam int CSR_W       = 64;
   localparam int CSR_IDX_W   = 2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_LEN  = 2'd2;

   typedef enum logic [1:0] {
      STAT_FOUND     = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_TOO_LONG  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FOLLOW,
      ST_BUILD,
      ST_BUILD_FOLLOW
   } state_type;

   typedef logic [PATTERN_MAX-1:0][7:0] pattern_type;

   typedef struct packed {
      status_type         status;
      logic [START_W-1:0] start;
   } out_item_type;

   typedef struct packed {
      logic         valid;
      out_item_type item;
   } result_type;

endpackage

// File: hw/rtl/kmp_fail_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module kmp_fail_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/kmp_engine.sv
// Failure-table builder and KMP search sequencer around the failure-table RAM.
`timescale 1ns / 1ps

module kmp_engine (
   input  logic                       clock,
   input  logic                       reset,
   input  kmp_pkg::pattern_type       pattern,
   input  logic [kmp_pkg::LEN_W-1:0]  plen,
   input  logic                       rebuild,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_text_byte,
   input  logic                       req_end_of_text,
   input  logic                       out_room,
   output kmp_pkg::result_type        result
);

   localparam int IDX_W = kmp_pkg::IDX_W;
   localparam int LEN_W = kmp_pkg::LEN_W;
   localparam int PB    = kmp_pkg::POS_BITS;

   kmp_pkg::state_type state_ff, state_in;

   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [LEN_W-1:0] matched_ff, matched_in;
   logic [PB:0]      pos_ff, pos_in;
   logic             done_ff, done_in;
   logic [7:0]       c_ff, c_in;
   logic             last_ff, last_in;

   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [IDX_W-1:0] mem_wdata;
   logic [IDX_W-1:0] mem_raddr;
   logic [IDX_W-1:0] mem_rdata;

   logic             accept;
   logic [IDX_W-1:0] q;
   logic [7:0]       cur_c;
   logic             cur_last;
   logic             pat_hit;
   logic             too_long;
   logic             fallback;
   logic [LEN_W-1:0] q_next;
   logic [PB:0]      start_sum;
   logic             bk_hit;
   logic             b_fallback;
   logic             b_last;
   logic [IDX_W-1:0] k_next;

   // Reads of the table during a build only target entries below the one being
   // written, which were written in earlier cycles: no forwarding is needed.
   kmp_fail_ram #(
      .DEPTH (kmp_pkg::PATTERN_MAX),
      .WIDTH (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_stall = !((state_ff == kmp_pkg::ST_IDLE) && out_room);
   assign accept    = req_valid && !req_stall;

   // search step: in FOLLOW the fallback length arrives from the RAM
   always_comb begin
      if (state_ff == kmp_pkg::ST_FOLLOW) begin
         q        = mem_rdata;
         cur_c    = c_ff;
         cur_last = last_ff;
      end else begin
         q        = (matched_ff >= plen) ? '0 : matched_ff[IDX_W-1:0];
         cur_c    = req_text_byte;
         cur_last = req_end_of_text;
      end
   end

   assign pat_hit   = (pattern[q] == cur_c);
   assign too_long  = pos_ff[PB];
   assign fallback  = !done_ff && !too_long && (q != '0) && !pat_hit;
   assign q_next    = LEN_W'(q) + LEN_W'(pat_hit);
   assign start_sum = pos_ff + (PB+1)'(1) - (PB+1)'(plen);

   // build step
   assign bk_hit     = (pattern[i_ff] == pattern[k_ff]);
   assign b_fallback = (i_ff != '0) && (k_ff != '0) && !bk_hit;
   assign b_last     = (LEN_W'(i_ff) == plen - LEN_W'(1));
   assign k_next     = (i_ff == '0) ? '0 : k_ff + IDX_W'(bk_hit);

   // next state
   always_comb begin
      state_in = state_ff;
      if (rebuild) begin
         state_in = kmp_pkg::ST_BUILD;
      end else begin
         unique case (state_ff)
            kmp_pkg::ST_IDLE: begin
               if (accept && fallback) state_in = kmp_pkg::ST_FOLLOW;
            end
            kmp_pkg::ST_FOLLOW: begin
               if (!fallback) state_in = kmp_pkg::ST_IDLE;
            end
            kmp_pkg::ST_BUILD: begin
               if (b_fallback)  state_in = kmp_pkg::ST_BUILD_FOLLOW;
               else if (b_last) state_in = kmp_pkg::ST_IDLE;
            end
            kmp_pkg::ST_BUILD_FOLLOW: begin
               state_in = kmp_pkg::ST_BUILD;
            end
            default: state_in = kmp_pkg::ST_BUILD;
         endcase
      end
   end

   // datapath and outputs
   always_comb begin
      i_in        = i_ff;
      k_in        = k_ff;
      matched_in  = matched_ff;
      pos_in      = pos_ff;
      done_in     = done_ff;
      c_in        = c_ff;
      last_in     = last_ff;
      mem_we      = 1'b0;
      mem_waddr   = i_ff;
      mem_wdata   = k_next;
      mem_raddr   = '0;
      result      = '0;

      if (rebuild) begin
         i_in       = '0;
         k_in       = '0;
         matched_in = '0;
      end else begin
         unique case (state_ff)
            kmp_pkg::ST_BUILD: begin
               if (b_fallback) begin
                  mem_raddr = k_ff - IDX_W'(1);
               end else begin
                  mem_we = 1'b1;
                  k_in   = k_next;
                  i_in   = i_ff + IDX_W'(1);
               end
            end
            kmp_pkg::ST_BUILD_FOLLOW: begin
               k_in = mem_rdata;
            end
            kmp_pkg::ST_IDLE, kmp_pkg::ST_FOLLOW: begin
               if (accept || state_ff == kmp_pkg::ST_FOLLOW) begin
                  if (fallback) begin
                     mem_raddr = q - IDX_W'(1);
                     c_in      = cur_c;
                     last_in   = cur_last;
                  end else begin
                     if (!done_ff) begin
                        if (too_long) begin
                           result.valid       = 1'b1;
                           result.item.status = kmp_pkg::STAT_TOO_LONG;
                           done_in            = 1'b1;
                        end else begin
                           matched_in = q_next;
                           if (q_next == plen) begin
                              result.valid       = 1'b1;
                              result.item.status = kmp_pkg::STAT_FOUND;
                              result.item.start  = kmp_pkg::START_W'(start_sum);
                              done_in            = 1'b1;
                           end else if (cur_last) begin
                              result.valid       = 1'b1;
                              result.item.status = kmp_pkg::STAT_NOT_FOUND;
                           end
                        end
                     end
                     // position saturates at the limit
                     if (!too_long) pos_in = pos_ff + (PB+1)'(1);
                     if (cur_last) begin
                        matched_in = '0;
                        pos_in     = '0;
                        done_in    = 1'b0;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= kmp_pkg::ST_BUILD;
         i_ff       <= '0;
         k_ff       <= '0;
         matched_ff <= '0;
         pos_ff     <= '0;
         done_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         i_ff       <= i_in;
         k_ff       <= k_in;
         matched_ff <= matched_in;
         pos_ff     <= pos_in;
         done_ff    <= done_in;
      end
      c_ff    <= c_in;
      last_ff <= last_in;
   end

endmodule

// File: hw/rtl/kmp_first_match_finder.sv
// Top level: configuration registers, search engine and two-entry result buffer.
`timescale 1ns / 1ps

// Finds the first occurrence of a pattern of 1 to 16 bytes in a byte stream,
// one text per run of bytes closed by req_end_of_text. Each text gives at most
// one result: found with the start index, not found at the last byte, or too
// long when a byte arrives at index 65536 or later. Every mismatch that falls
// back adds a failure-table lookup before the byte is done; the
// failure table sits in a RAM with one read port, so lookups run one per cycle.
// Since the matched length falls back at most as often as it grew, a text
// needs no more lookups than it has bytes. After reset and after every write
// of a pattern register the failure table is rebuilt, and req_stall is high
// meanwhile. Results wait in a two-entry buffer, so the input side keeps
// moving while one result is stalled.

module kmp_first_match_finder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_text_byte,
   input  logic                              req_end_of_text,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [kmp_pkg::START_W-1:0]       rsp_start_position,
   input  logic                              csr_we,
   input  logic [kmp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kmp_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int LEN_W = kmp_pkg::LEN_W;

   logic [63:0]      pat_low_ff, pat_low_in;
   logic [63:0]      pat_high_ff, pat_high_in;
   logic [4:0]       pat_len_ff, pat_len_in;
   logic             rebuild;
   logic [LEN_W-1:0] plen;

   kmp_pkg::result_type   result;
   kmp_pkg::out_item_type slot_ff [2];
   kmp_pkg::out_item_type slot_in [2];
   logic [1:0]            count_ff, count_in;
   logic                  pop;

   assign rebuild = csr_we && (csr_index <= kmp_pkg::CSR_PAT_LEN);

   always_comb begin
      pat_low_in  = pat_low_ff;
      pat_high_in = pat_high_ff;
      pat_len_in  = pat_len_ff;
      if (csr_we) begin
         unique case (csr_index)
            kmp_pkg::CSR_PAT_LOW:  pat_low_in  = csr_wdata;
            kmp_pkg::CSR_PAT_HIGH: pat_high_in = csr_wdata;
            kmp_pkg::CSR_PAT_LEN:  pat_len_in  = csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // zero acts as one, anything above the maximum as the maximum
   always_comb begin
      if (pat_len_ff == '0) begin
         plen = LEN_W'(1);
      end else if (pat_len_ff > 5'(kmp_pkg::PATTERN_MAX)) begin
         plen = LEN_W'(kmp_pkg::PATTERN_MAX);
      end else begin
         plen = LEN_W'(pat_len_ff);
      end
   end

   kmp_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .pattern         ({pat_high_ff, pat_low_ff}),
      .plen            (plen),
      .rebuild         (rebuild),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .out_room        (count_ff != 2'd2),
      .result          (result)
   );

   // result buffer, head always in slot 0
   assign pop = rsp_valid && !rsp_stall;

   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      count_in   = count_ff;
      if (pop) begin
         slot_in[0] = slot_ff[1];
         count_in   = count_in - 2'd1;
      end
      if (result.valid) begin
         if (count_in == 2'd0) slot_in[0] = result.item;
         else                  slot_in[1] = result.item;
         count_in = count_in + 2'd1;
      end
   end

   assign rsp_valid          = (count_ff != 2'd0);
   assign rsp_status         = slot_ff[0].status;
   assign rsp_start_position = slot_ff[0].start;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= 5'd1;
         count_ff    <= '0;
      end else begin
         pat_low_ff  <= pat_low_in;
         pat_high_ff <= pat_high_in;
         pat_len_ff  <= pat_len_in;
         count_ff    <= count_in;
      end
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

endmodule

// File: hw/rtl/kmp_checker.sv
// Port-level assertions for the KMP first-match finder, bound to the top level.
`timescale 1ns / 1ps

module kmp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic [7:0]                        req_text_byte,
   input logic                              req_end_of_text,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [1:0]                        rsp_status,
   input logic [kmp_pkg::START_W-1:0]       rsp_start_position,
   input logic                              csr_we,
   input logic [kmp_pkg::CSR_IDX_W-1:0]     csr_index
);

   // the failure table is being built right after reset
   a_stall_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input taken while failure table rebuilds after reset");

   // a pattern register write triggers a rebuild
   a_stall_after_csr: assert property (@(posedge clock) disable iff (reset)
      (csr_we && csr_index <= kmp_pkg::CSR_PAT_LEN) |=> req_stall)
      else $error("input taken while failure table rebuilds after write");

   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != kmp_pkg::STAT_FOUND) |-> rsp_start_position == '0)
      else $error("nonzero start position without a match");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_start_position)))
      else $error("stalled result transfer changed");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=>
         (req_valid && $stable(req_text_byte) && $stable(req_end_of_text)))
      else $error("stalled input transfer changed");

endmodule

bind kmp_first_match_finder kmp_checker u_kmp_checker (.*);
